[sv/prd_pkg.sv]
// Shared types, quadrant codes and the quarter-wave sine table for the rotator.
`timescale 1ns / 1ps

package prd_pkg;

  // Sine and cosine coefficients, scale 32767, signed.
  localparam int COEF_BITS = 16;
  typedef logic signed [COEF_BITS-1:0] coef_t;

  // Reduced angle held after a configuration write.
  localparam int QUAD_BITS = 2;
  localparam int REM_BITS  = 7;
  typedef logic [QUAD_BITS-1:0] quad_t;
  typedef logic [REM_BITS-1:0]  rem_t;

  typedef struct packed {
    quad_t quad;
    rem_t  rem;
  } angle_t;

  localparam quad_t QUAD_0 = 2'd0;
  localparam quad_t QUAD_1 = 2'd1;
  localparam quad_t QUAD_2 = 2'd2;
  localparam quad_t QUAD_3 = 2'd3;

  localparam int ANGLE_BITS = 9;
  localparam int FULL_TURN  = 360;
  localparam int QUARTER    = 90;

  // round(32767 * sin(d degrees)), d = 0..90
  localparam logic [14:0] SIN_Q [0:90] = '{
        15'd0,   15'd572,  15'd1144,  15'd1715,  15'd2286,
     15'd2856,  15'd3425,  15'd3993,  15'd4560,  15'd5126,
     15'd5690,  15'd6252,  15'd6813,  15'd7371,  15'd7927,
     15'd8481,  15'd9032,  15'd9580, 15'd10126, 15'd10668,
    15'd11207, 15'd11743, 15'd12275, 15'd12803, 15'd13328,
    15'd13848, 15'd14364, 15'd14876, 15'd15383, 15'd15886,
    15'd16384, 15'd16876, 15'd17364, 15'd17846, 15'd18323,
    15'd18794, 15'd19260, 15'd19720, 15'd20173, 15'd20621,
    15'd21062, 15'd21497, 15'd21925, 15'd22347, 15'd22762,
    15'd23170, 15'd23571, 15'd23964, 15'd24351, 15'd24730,
    15'd25101, 15'd25465, 15'd25821, 15'd26169, 15'd26509,
    15'd26841, 15'd27165, 15'd27481, 15'd27788, 15'd28087,
    15'd28377, 15'd28659, 15'd28932, 15'd29196, 15'd29451,
    15'd29697, 15'd29934, 15'd30162, 15'd30381, 15'd30591,
    15'd30791, 15'd30982, 15'd31163, 15'd31335, 15'd31498,
    15'd31650, 15'd31794, 15'd31927, 15'd32051, 15'd32165,
    15'd32269, 15'd32364, 15'd32448, 15'd32523, 15'd32587,
    15'd32642, 15'd32687, 15'd32722, 15'd32747, 15'd32762,
    15'd32767
  };

endpackage

[sv/prd_coef.sv]
// Sine and cosine lookup with quadrant folding for a reduced angle.
`timescale 1ns / 1ps

module prd_coef (
  input  prd_pkg::angle_t angle,
  output prd_pkg::coef_t  sin_coef,
  output prd_pkg::coef_t  cos_coef
);

  prd_pkg::rem_t  rem_mirror;
  prd_pkg::coef_t s_mag;
  prd_pkg::coef_t c_mag;

  // Look up the sine of the remainder and of its complement
  assign rem_mirror = prd_pkg::rem_t'(prd_pkg::QUARTER) - angle.rem;
  assign s_mag = prd_pkg::coef_t'({1'b0, prd_pkg::SIN_Q[angle.rem]});
  assign c_mag = prd_pkg::coef_t'({1'b0, prd_pkg::SIN_Q[rem_mirror]});

  // Fold into the quadrant
  always_comb begin
    case (angle.quad)
      prd_pkg::QUAD_0: begin
        sin_coef = s_mag;
        cos_coef = c_mag;
      end
      prd_pkg::QUAD_1: begin
        sin_coef = c_mag;
        cos_coef = -s_mag;
      end
      prd_pkg::QUAD_2: begin
        sin_coef = -s_mag;
        cos_coef = -c_mag;
      end
      default: begin
        sin_coef = -c_mag;
        cos_coef = s_mag;
      end
    endcase
  end

endmodule

[sv/point_rotation_by_degrees.sv]
// Top level: pipelined rotation of integer points by a configured angle.
`timescale 1ns / 1ps

// Rotates each point (point_x, point_y) counterclockwise by angle_degrees.
// Results rotated_x, rotated_y are signed with 8 fractional bits.
// Input channel: in_valid / in_stall, a word is taken when in_valid is high
// and in_stall is low. Output channel: out_valid / out_stall, same rule.
// Configuration: angle_degrees is written when cfg_valid and cfg_ready are
// both high; cfg_ready is always high. Values of 360 and up wrap modulo 360.
// Write it only while no point is in flight.
// Pipeline: coefficient lookup, four multipliers, two adders, rounding and
// output register. One point is taken in every cycle while the receiver does
// not stall; the four register stages lie between a point and its result, the
// first of them loading at the edge that takes the point.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall goes high in the same cycle; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits and sets the angle to 0.
module point_rotation_by_degrees #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [prd_pkg::ANGLE_BITS-1:0]        angle_degrees,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          point_x,
  input  logic signed [COORD_BITS-1:0]          point_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [24:0]                    rotated_x,
  output logic signed [24:0]                    rotated_y
);

  localparam int OUT_BITS  = 25;
  localparam int PROD_BITS = COORD_BITS + prd_pkg::COEF_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int EXT_BITS  = SUM_BITS + OUT_BITS;

  prd_pkg::angle_t angle;
  prd_pkg::angle_t angle_next;
  logic [prd_pkg::ANGLE_BITS-1:0] wrapped;

  prd_pkg::coef_t sin_coef;
  prd_pkg::coef_t cos_coef;

  logic advance;

  // Stage 1: point and coefficients
  logic                           v1;
  logic signed [COORD_BITS-1:0]   x1;
  logic signed [COORD_BITS-1:0]   y1;
  prd_pkg::coef_t                 s1;
  prd_pkg::coef_t                 c1;

  // Stage 2: products
  logic                           v2;
  logic signed [PROD_BITS-1:0]    xc2;
  logic signed [PROD_BITS-1:0]    ys2;
  logic signed [PROD_BITS-1:0]    xs2;
  logic signed [PROD_BITS-1:0]    yc2;

  // Stage 3: sums
  logic                           v3;
  logic signed [SUM_BITS-1:0]     sx3;
  logic signed [SUM_BITS-1:0]     sy3;

  // Rounding ahead of the output register
  logic signed [SUM_BITS-1:0]     rx;
  logic signed [SUM_BITS-1:0]     ry;
  logic signed [EXT_BITS-1:0]     rx_ext;
  logic signed [EXT_BITS-1:0]     ry_ext;

  assign cfg_ready = 1'b1;

  // Reduce the written angle to quadrant and remainder
  always_comb begin
    if (angle_degrees >= prd_pkg::ANGLE_BITS'(prd_pkg::FULL_TURN)) begin
      wrapped = angle_degrees - prd_pkg::ANGLE_BITS'(prd_pkg::FULL_TURN);
    end else begin
      wrapped = angle_degrees;
    end
    if (wrapped < prd_pkg::ANGLE_BITS'(prd_pkg::QUARTER)) begin
      angle_next.quad = prd_pkg::QUAD_0;
      angle_next.rem  = prd_pkg::rem_t'(wrapped);
    end else if (wrapped < prd_pkg::ANGLE_BITS'(2 * prd_pkg::QUARTER)) begin
      angle_next.quad = prd_pkg::QUAD_1;
      angle_next.rem  = prd_pkg::rem_t'(wrapped - prd_pkg::ANGLE_BITS'(prd_pkg::QUARTER));
    end else if (wrapped < prd_pkg::ANGLE_BITS'(3 * prd_pkg::QUARTER)) begin
      angle_next.quad = prd_pkg::QUAD_2;
      angle_next.rem  = prd_pkg::rem_t'(wrapped - prd_pkg::ANGLE_BITS'(2 * prd_pkg::QUARTER));
    end else begin
      angle_next.quad = prd_pkg::QUAD_3;
      angle_next.rem  = prd_pkg::rem_t'(wrapped - prd_pkg::ANGLE_BITS'(3 * prd_pkg::QUARTER));
    end
  end

  // Hold the reduced angle
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '{quad: prd_pkg::QUAD_0, rem: '0};
    end else if (cfg_valid && cfg_ready) begin
      angle <= angle_next;
    end
  end

  prd_coef u_coef (
    .angle    (angle),
    .sin_coef (sin_coef),
    .cos_coef (cos_coef)
  );

  // Advance the whole pipeline unless a result waits on a stalled receiver
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // Round as (sum + 64) >>> 7, then wrap to the output width
  assign rx     = (sx3 + SUM_BITS'(64)) >>> 7;
  assign ry     = (sy3 + SUM_BITS'(64)) >>> 7;
  assign rx_ext = EXT_BITS'(rx);
  assign ry_ext = EXT_BITS'(ry);

  // Data stages
  always_ff @(posedge clk) begin
    if (advance) begin
      x1 <= point_x;
      y1 <= point_y;
      s1 <= sin_coef;
      c1 <= cos_coef;

      xc2 <= PROD_BITS'(x1) * PROD_BITS'(c1);
      ys2 <= PROD_BITS'(y1) * PROD_BITS'(s1);
      xs2 <= PROD_BITS'(x1) * PROD_BITS'(s1);
      yc2 <= PROD_BITS'(y1) * PROD_BITS'(c1);

      sx3 <= SUM_BITS'(xc2) - SUM_BITS'(ys2);
      sy3 <= SUM_BITS'(xs2) + SUM_BITS'(yc2);

      rotated_x <= rx_ext[OUT_BITS-1:0];
      rotated_y <= ry_ext[OUT_BITS-1:0];
    end
  end

endmodule

[verif/rotation_checker.sv]
// Checker for the point rotator: tracks the angle, predicts rotated points, compares results.
`timescale 1ns / 1ps

module rotation_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [prd_pkg::ANGLE_BITS-1:0]   angle_degrees,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic signed [15:0]               point_x,
  input  logic signed [15:0]               point_y,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [24:0]               rotated_x,
  input  logic signed [24:0]               rotated_y,
  output int                               error_count,
  output int                               outstanding
);

  typedef struct packed {
    logic signed [24:0] rx;
    logic signed [24:0] ry;
  } rotated_t;

  // round(32767 * sin(d degrees)), d = 0..90
  localparam int SINE_Q15 [0:90] = '{
        0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
     5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14364, 14876, 15383, 15886,
    16384, 16876, 17364, 17846, 18323, 18794, 19260, 19720, 20173, 20621,
    21062, 21497, 21925, 22347, 22762, 23170, 23571, 23964, 24351, 24730,
    25101, 25465, 25821, 26169, 26509, 26841, 27165, 27481, 27788, 28087,
    28377, 28659, 28932, 29196, 29451, 29697, 29934, 30162, 30381, 30591,
    30791, 30982, 31163, 31335, 31498, 31650, 31794, 31927, 32051, 32165,
    32269, 32364, 32448, 32523, 32587, 32642, 32687, 32722, 32747, 32762,
    32767
  };

  logic [prd_pkg::ANGLE_BITS-1:0] angle_q;
  rotated_t                       rotated_q [$];

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  // Rotate one point by the given register value; round (sum + 64) >>> 7 to 25 bits.
  function automatic rotated_t rotate_point(input logic [prd_pkg::ANGLE_BITS-1:0] ang,
                                            input logic signed [15:0] px,
                                            input logic signed [15:0] py);
    int             folded;
    int             frac;
    prd_pkg::quad_t quad;
    longint         s;
    longint         c;
    longint         sum_x;
    longint         sum_y;
    rotated_t       res;
    folded = int'(ang) % prd_pkg::FULL_TURN;
    quad   = prd_pkg::quad_t'(folded / prd_pkg::QUARTER);
    frac   = folded % prd_pkg::QUARTER;
    case (quad)
      prd_pkg::QUAD_0: begin
        s = SINE_Q15[frac];
        c = SINE_Q15[prd_pkg::QUARTER - frac];
      end
      prd_pkg::QUAD_1: begin
        s = SINE_Q15[prd_pkg::QUARTER - frac];
        c = -SINE_Q15[frac];
      end
      prd_pkg::QUAD_2: begin
        s = -SINE_Q15[frac];
        c = -SINE_Q15[prd_pkg::QUARTER - frac];
      end
      default: begin
        s = -SINE_Q15[prd_pkg::QUARTER - frac];
        c = SINE_Q15[frac];
      end
    endcase
    sum_x = longint'(px) * c - longint'(py) * s;
    sum_y = longint'(px) * s + longint'(py) * c;
    sum_x = (sum_x + 64) >>> 7;
    sum_y = (sum_y + 64) >>> 7;
    res.rx = sum_x[24:0];
    res.ry = sum_y[24:0];
    return res;
  endfunction

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    rotated_t want;
    if (rst) begin
      angle_q = '0;
      rotated_q.delete();
    end else begin
      // Track the angle register
      if (cfg_valid && cfg_ready) begin
        angle_q = angle_degrees;
      end
      // Compare an accepted result word with the oldest prediction
      if (out_valid && !out_stall) begin
        if (rotated_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result x=%0d y=%0d", rotated_x, rotated_y));
        end else begin
          want = rotated_q.pop_front();
          if (rotated_x !== want.rx) begin
            report_mismatch($sformatf("rotated_x got %0d want %0d", rotated_x, want.rx));
          end
          if (rotated_y !== want.ry) begin
            report_mismatch($sformatf("rotated_y got %0d want %0d", rotated_y, want.ry));
          end
        end
      end
      // Predict for an accepted point word
      if (in_valid && !in_stall) begin
        rotated_q.push_back(rotate_point(angle_q, point_x, point_y));
      end
    end
    outstanding = rotated_q.size();
  end

endmodule

[verif/tb_point_rotation_by_degrees.sv]
// Top testbench for the point rotator: clock, reset, stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb_point_rotation_by_degrees;

  localparam int NUM_PHASES     = 13;
  localparam int PHASE_POINTS   = 150;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;

  logic                             clk           = 1'b0;
  logic                             rst           = 1'b1;
  logic                             cfg_valid     = 1'b0;
  logic                             cfg_ready;
  logic [prd_pkg::ANGLE_BITS-1:0]   angle_degrees = '0;
  logic                             in_valid      = 1'b0;
  logic                             in_stall;
  logic signed [15:0]               point_x       = '0;
  logic signed [15:0]               point_y       = '0;
  logic                             out_valid;
  logic                             out_stall     = 1'b0;
  logic signed [24:0]               rotated_x;
  logic signed [24:0]               rotated_y;

  int error_count;
  int outstanding;
  int idle_cycles    = 0;
  int stall_mode     = 0;
  int stall_left     = 0;
  int stall_tick     = 0;
  int burst_left     = 0;
  bit gaps_enabled   = 1'b1;

  point_rotation_by_degrees #(.COORD_BITS(16)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .angle_degrees (angle_degrees),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .point_x       (point_x),
    .point_y       (point_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .rotated_x     (rotated_x),
    .rotated_y     (rotated_y)
  );

  rotation_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .angle_degrees (angle_degrees),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .point_x       (point_x),
    .point_y       (point_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .rotated_x     (rotated_x),
    .rotated_y     (rotated_y),
    .error_count   (error_count),
    .outstanding   (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result channel on a changing pattern: none, light, heavy, periodic
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(40, 160);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 20);
      2:       out_stall <= ($urandom_range(0, 99) < 75);
      default: out_stall <= ((stall_tick % 5) < 2);
    endcase
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
        (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Pick a coordinate: extremes, small values near zero, or full random
  function automatic logic signed [15:0] pick_coord();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'($signed($urandom_range(0, 16)) - 8);
      default: return raw[15:0];
    endcase
  endfunction

  // Write the angle register; call only with nothing in flight
  task automatic write_angle(input logic [prd_pkg::ANGLE_BITS-1:0] ang);
    cfg_valid     <= 1'b1;
    angle_degrees <= ang;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offer one point word and hold it until taken; return at a falling edge
  task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py);
    if (burst_left == 0) begin
      int gap;
      gap = gaps_enabled ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    point_x  <= px;
    point_y  <= py;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted result has arrived
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Send the first count points of a list: coordinate-range corners, then small points
  task automatic send_corners(input int count);
    logic signed [15:0] cx [0:7];
    logic signed [15:0] cy [0:7];
    cx = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd100};
    cy = '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1, 16'sd0};
    for (int i = 0; i < count; i++) begin
      send_point(cx[i], cy[i]);
    end
  endtask

  initial begin
    logic [prd_pkg::ANGLE_BITS-1:0] edge_angles [0:7];
    logic [prd_pkg::ANGLE_BITS-1:0] ang;
    edge_angles = '{9'd0, 9'd359, 9'd360, 9'd511, 9'd90, 9'd180, 9'd270, 9'd1};

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset angle, the exact-half table entry, wrapped angles, quadrant edges
    send_corners(2);
    wait_idle();
    write_angle(9'd30);
    send_corners(8);
    wait_idle();
    write_angle(9'd400);
    send_corners(2);
    wait_idle();
    write_angle(9'd511);
    send_corners(2);
    wait_idle();
    write_angle(9'd90);
    send_corners(2);
    wait_idle();
    write_angle(9'd180);
    send_corners(2);
    wait_idle();
    write_angle(9'd270);
    send_corners(2);
    wait_idle();
    write_angle(9'd359);
    send_corners(2);
    wait_idle();

    // Random points in phases, one angle each, edge_angles first; every fourth phase streams with no gaps
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      ang = (ph < 8) ? edge_angles[ph] : 9'($urandom_range(0, 511));
      write_angle(ang);
      gaps_enabled = ((ph % 4) != 3);
      burst_left   = 0;
      for (int n = 0; n < PHASE_POINTS; n++) begin
        send_point(pick_coord(), pick_coord());
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
